### rtl/mass_spring_chain_step_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mass-spring chain block
// Clocked, reset-qualified implication forms shared by the checker.
// ----------------------------------------------------------------------------
`ifndef MASS_SPRING_CHAIN_STEP_ASSERT_SVH
`define MASS_SPRING_CHAIN_STEP_ASSERT_SVH

// Same-cycle implication.
`define MSCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MSCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// Mass-spring chain package
// Sizes, codes, sequencer states and saturation helper for the chain block.
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam int NUM_MASSES    = 16;
    localparam int MW            = $clog2(NUM_MASSES);
    localparam int MAX_OUT       = (NUM_MASSES < 16) ? NUM_MASSES : 16;
    localparam int GRAVITY_SCALE = 1000;
    localparam int DIV_STEPS     = 64;
    localparam int DIV_CW        = $clog2(DIV_STEPS);
    localparam int SQRT_STEPS    = 32;
    localparam int SQRT_CW       = $clog2(SQRT_STEPS);
    localparam int IN_W          = 104;
    localparam int OUT_W         = 104;

    typedef logic [MW-1:0] midx_t;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESTORE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        CFG_STIFFNESS = 3'd0,
        CFG_DAMPING   = 3'd1,
        CFG_RATE      = 3'd2,
        CFG_GRAVITY   = 3'd3,
        CFG_COUNT     = 3'd4
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RS_COPY,
        ST_TK_FK,
        ST_TK_FZ,
        ST_TK_GV,
        ST_TK_GS,
        ST_LK_RDA,
        ST_LK_RDB,
        ST_LK_SQ,
        ST_LK_ACC,
        ST_LK_SQRT,
        ST_LK_REST,
        ST_LK_ST,
        ST_LK_ST2,
        ST_LK_FA,
        ST_LK_FB,
        ST_LK_FC,
        ST_LK_FD,
        ST_LK_DIV,
        ST_LK_WA,
        ST_LK_WB,
        ST_MS_GRAV,
        ST_MS_DV,
        ST_MS_DVW,
        ST_MS_DP,
        ST_MS_DPW,
        ST_MS_CLR,
        ST_MS_OUT
    } state_t;

    // Clamp a signed 64-bit value into the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/mass_spring_chain_step.sv
// A load is written without leaving the idle state. A restore copies every home position back,
// then measures each link. A tick runs a setup, then each link of the n masses (a zero-length
// link skips the force steps), then each mass, free or anchored; the 64-step serial
// divider does most of the work, and a stalled result holds the sequencer.
// Input is taken only in the idle state; results leave through an output register.
// rst_n clears the configuration and control registers to their defaults and every mass to the origin, anchored.
// ----------------------------------------------------------------------------
// Mass-spring chain stepper
// Sequencer over a shared multiplier, serial root and serial divider that
// accumulates link forces and integrates the masses by symplectic Euler.
// ----------------------------------------------------------------------------
module mass_spring_chain_step
(
    input  logic                        clk,
    input  logic                        rst_n,
    // Input stream. tdata from bit 0: mass_index, load_x, load_y, load_z, load_fixed.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [msc_pkg::IN_W-1:0]    s_tdata,
    // tuser: opcode.
    input  logic [1:0]                  s_tuser,
    // Output stream. tdata from bit 0: out_index, out_x, out_y, out_z.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [msc_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tlast,
    // Configuration write channel.
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_addr,
    input  logic [16:0]                 cfg_data
);

    // Configuration registers.
    logic [16:0] stiff_reg;
    logic [16:0] damp_reg;
    logic [9:0]  rate_reg;
    logic [16:0] grav_lvl_reg;
    logic [4:0]  count_reg;

    // Per-mass state.
    logic signed [31:0] pos_reg   [msc_pkg::NUM_MASSES][3];
    logic signed [31:0] vel_reg   [msc_pkg::NUM_MASSES][3];
    logic signed [31:0] home_reg  [msc_pkg::NUM_MASSES][3];
    logic signed [31:0] frc_reg   [msc_pkg::NUM_MASSES][3];
    logic signed [31:0] rest_reg  [msc_pkg::NUM_MASSES];
    logic               anch_reg  [msc_pkg::NUM_MASSES];

    // Sequencer and working registers.
    msc_pkg::state_t    state_reg, state_next;
    msc_pkg::midx_t     idx_reg, idx_next;
    logic [1:0]         ax_reg, ax_next;
    logic               md_reg, md_next;
    logic signed [31:0] pa_reg [3], pa_next [3];
    logic signed [31:0] va_reg [3], va_next [3];
    logic signed [31:0] dlt_reg [3], dlt_next [3];
    logic signed [32:0] dv_reg [3], dv_next [3];
    logic [63:0]        acc_reg, acc_next;
    logic [31:0]        d_reg, d_next;
    logic [26:0]        fk_reg, fk_next;
    logic [26:0]        fz_reg, fz_next;
    logic [26:0]        grav_reg, grav_next;
    logic signed [63:0] sterm_reg, sterm_next;
    logic signed [31:0] f_reg, f_next;
    logic signed [32:0] c_reg, c_next;
    logic signed [63:0] prod_reg;

    // Output register.
    logic               ov_reg, ov_next;
    logic               oload;
    logic [3:0]         oidx_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic               olast_reg;

    // Store access.
    msc_pkg::midx_t     ad;
    logic signed [31:0] rd_pos [3];
    logic signed [31:0] rd_vel [3];
    logic signed [31:0] rd_home [3];
    logic signed [31:0] rd_frc [3];
    logic signed [31:0] rd_rest;
    logic               rd_anch;
    logic [2:0]         pos_we, vel_we, frc_we;
    logic signed [31:0] pos_wd [3];
    logic signed [31:0] vel_wd [3];
    logic signed [31:0] frc_wd [3];
    logic               home_we, rest_we, anch_we;
    logic signed [31:0] rest_wd;
    logic               anch_wd;

    // Shared arithmetic.
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_full;
    logic [63:0]        acc_sum;
    logic               sq_start, sq_done;
    logic [31:0]        sq_root;
    logic               dv_start, dv_done;
    logic signed [63:0] dv_num, dv_quot;
    logic [32:0]        dv_den;

    // Decoded input and derived control values.
    msc_pkg::op_t       in_op;
    logic [3:0]         in_idx;
    logic signed [31:0] in_xyz [3];
    logic               in_fixed;
    logic [9:0]         fe;
    logic [4:0]         n_eff, n_last, link_last;
    logic               link_done;
    logic signed [63:0] s_wide;
    logic signed [31:0] s_val;
    logic signed [63:0] fsum, fq;

    // Input field unpacking.
    assign in_op     = msc_pkg::op_t'(s_tuser);
    assign in_idx    = s_tdata[3:0];
    assign in_xyz[0] = s_tdata[35:4];
    assign in_xyz[1] = s_tdata[67:36];
    assign in_xyz[2] = s_tdata[99:68];
    assign in_fixed  = s_tdata[100];

    // Effective rate and mass count.
    assign fe = (rate_reg == 10'd0) ? 10'd1 : rate_reg;
    always_comb
    begin
        if (count_reg > 5'(msc_pkg::MAX_OUT))
        begin
            n_eff = 5'(msc_pkg::MAX_OUT);
        end
        else if (count_reg < 5'd2)
        begin
            n_eff = 5'd2;
        end
        else
        begin
            n_eff = count_reg;
        end
    end
    assign n_last    = n_eff - 5'd1;
    assign link_last = n_eff - 5'd2;
    assign link_done = md_reg ? (8'(idx_reg) == 8'(msc_pkg::NUM_MASSES - 2))
                              : (8'(idx_reg) == 8'(link_last));

    // Read port of the mass store.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            rd_pos[a]  = pos_reg[ad][a];
            rd_vel[a]  = vel_reg[ad][a];
            rd_home[a] = home_reg[ad][a];
            rd_frc[a]  = frc_reg[ad][a];
        end
        rd_rest = rest_reg[ad];
        rd_anch = anch_reg[ad];
    end

    // Shared multiplier and other arithmetic around it.
    assign mul_full = mul_a * mul_b;
    assign acc_sum  = acc_reg + $unsigned(prod_reg);
    assign s_wide   = $signed({32'b0, d_reg}) - 64'(rd_rest);
    assign s_val    = msc_pkg::sat32(s_wide);
    assign fsum     = sterm_reg + prod_reg;
    assign fq       = (fsum + (fsum[63] ? 64'sd65535 : 64'sd0)) >>> 16;

    msc_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (acc_sum),
        .done  (sq_done),
        .root  (sq_root)
    );

    msc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dv_num),
        .divisor  (dv_den),
        .done     (dv_done),
        .quot     (dv_quot)
    );

    // Configuration writes; always ready.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg    <= 17'd6554;
            damp_reg     <= 17'd655;
            rate_reg     <= 10'd100;
            grav_lvl_reg <= 17'd0;
            count_reg    <= 5'd13;
        end
        else if (cfg_valid)
        begin
            case (msc_pkg::cfg_idx_t'(cfg_addr))
                msc_pkg::CFG_STIFFNESS: stiff_reg    <= cfg_data;
                msc_pkg::CFG_DAMPING:   damp_reg     <= cfg_data;
                msc_pkg::CFG_RATE:      rate_reg     <= cfg_data[9:0];
                msc_pkg::CFG_GRAVITY:   grav_lvl_reg <= cfg_data;
                msc_pkg::CFG_COUNT:     count_reg    <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Sequencer: next state, store writes and unit control.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ax_next    = ax_reg;
        md_next    = md_reg;
        pa_next    = pa_reg;
        va_next    = va_reg;
        dlt_next   = dlt_reg;
        dv_next    = dv_reg;
        acc_next   = acc_reg;
        d_next     = d_reg;
        fk_next    = fk_reg;
        fz_next    = fz_reg;
        grav_next  = grav_reg;
        sterm_next = sterm_reg;
        f_next     = f_reg;
        c_next     = c_reg;
        ov_next    = ov_reg && !m_tready;
        oload      = 1'b0;
        ad         = idx_reg;
        mul_a      = '0;
        mul_b      = '0;
        sq_start   = 1'b0;
        dv_start   = 1'b0;
        dv_num     = prod_reg;
        dv_den     = {1'b0, d_reg};
        pos_we     = '0;
        vel_we     = '0;
        frc_we     = '0;
        pos_wd     = rd_pos;
        vel_wd     = rd_vel;
        frc_wd     = rd_frc;
        home_we    = 1'b0;
        rest_we    = 1'b0;
        rest_wd    = rd_rest;
        anch_we    = 1'b0;
        anch_wd    = rd_anch;

        case (state_reg)
            msc_pkg::ST_IDLE:
            begin
                ad = msc_pkg::midx_t'(in_idx);
                if (s_tvalid)
                begin
                    case (in_op)
                        msc_pkg::OP_LOAD:
                        begin
                            if (8'(in_idx) < 8'(msc_pkg::NUM_MASSES))
                            begin
                                pos_we  = 3'b111;
                                pos_wd  = in_xyz;
                                home_we = 1'b1;
                                vel_we  = 3'b111;
                                vel_wd  = '{default: '0};
                                anch_we = 1'b1;
                                anch_wd = in_fixed;
                            end
                        end
                        msc_pkg::OP_TICK:
                        begin
                            md_next    = 1'b0;
                            state_next = msc_pkg::ST_TK_FK;
                        end
                        msc_pkg::OP_RESTORE:
                        begin
                            md_next    = 1'b1;
                            idx_next   = '0;
                            state_next = msc_pkg::ST_RS_COPY;
                        end
                        default: ;
                    endcase
                end
            end

            // Restore: copy home to position and clear motion, one mass a cycle.
            msc_pkg::ST_RS_COPY:
            begin
                pos_we = 3'b111;
                pos_wd = rd_home;
                vel_we = 3'b111;
                vel_wd = '{default: '0};
                frc_we = 3'b111;
                frc_wd = '{default: '0};
                if (idx_reg == msc_pkg::midx_t'(msc_pkg::NUM_MASSES - 1))
                begin
                    idx_next   = '0;
                    state_next = msc_pkg::ST_LK_RDA;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Tick setup: rate-scaled gains and the gravity term.
            msc_pkg::ST_TK_FK:
            begin
                mul_a      = {24'b0, fe};
                mul_b      = {17'b0, stiff_reg};
                state_next = msc_pkg::ST_TK_FZ;
            end
            msc_pkg::ST_TK_FZ:
            begin
                fk_next    = prod_reg[26:0];
                mul_a      = {24'b0, fe};
                mul_b      = {17'b0, damp_reg};
                state_next = msc_pkg::ST_TK_GV;
            end
            msc_pkg::ST_TK_GV:
            begin
                fz_next    = prod_reg[26:0];
                mul_a      = {17'b0, grav_lvl_reg};
                mul_b      = 34'(msc_pkg::GRAVITY_SCALE);
                state_next = msc_pkg::ST_TK_GS;
            end
            msc_pkg::ST_TK_GS:
            begin
                grav_next  = prod_reg[26:0];
                idx_next   = '0;
                state_next = msc_pkg::ST_LK_RDA;
            end

            // Link: fetch both ends and form the deltas.
            msc_pkg::ST_LK_RDA:
            begin
                pa_next    = rd_pos;
                va_next    = rd_vel;
                state_next = msc_pkg::ST_LK_RDB;
            end
            msc_pkg::ST_LK_RDB:
            begin
                ad = idx_reg + 1'b1;
                for (int a = 0; a < 3; a++)
                begin
                    dlt_next[a] = msc_pkg::sat32(64'(rd_pos[a]) - 64'(pa_reg[a]));
                    dv_next[a]  = 33'(rd_vel[a]) - 33'(va_reg[a]);
                end
                acc_next   = '0;
                ax_next    = '0;
                state_next = msc_pkg::ST_LK_SQ;
            end

            // Sum of squared deltas, then the root.
            msc_pkg::ST_LK_SQ:
            begin
                mul_a      = 34'(dlt_reg[ax_reg]);
                mul_b      = 34'(dlt_reg[ax_reg]);
                state_next = msc_pkg::ST_LK_ACC;
            end
            msc_pkg::ST_LK_ACC:
            begin
                acc_next = acc_sum;
                if (ax_reg == 2'd2)
                begin
                    sq_start   = 1'b1;
                    state_next = msc_pkg::ST_LK_SQRT;
                end
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = msc_pkg::ST_LK_SQ;
                end
            end
            msc_pkg::ST_LK_SQRT:
            begin
                if (sq_done)
                begin
                    d_next = sq_root;
                    if (md_reg)
                    begin
                        state_next = msc_pkg::ST_LK_REST;
                    end
                    else if (sq_root != 32'd0)
                    begin
                        state_next = msc_pkg::ST_LK_ST;
                    end
                    else if (link_done)
                    begin
                        idx_next   = '0;
                        state_next = msc_pkg::ST_MS_GRAV;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = msc_pkg::ST_LK_RDA;
                    end
                end
            end

            // Restore: keep the length as the rest length.
            msc_pkg::ST_LK_REST:
            begin
                rest_we = 1'b1;
                rest_wd = d_reg[31] ? 32'sh7FFF_FFFF : $signed(d_reg);
                if (link_done)
                begin
                    state_next = msc_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = msc_pkg::ST_LK_RDA;
                end
            end

            // Stretch term shared by the three axes.
            msc_pkg::ST_LK_ST:
            begin
                mul_a      = {7'b0, fk_reg};
                mul_b      = 34'(s_val);
                state_next = msc_pkg::ST_LK_ST2;
            end
            msc_pkg::ST_LK_ST2:
            begin
                sterm_next = prod_reg;
                ax_next    = '0;
                state_next = msc_pkg::ST_LK_FA;
            end

            // Per axis: spring-damper force, projection and accumulation.
            msc_pkg::ST_LK_FA:
            begin
                mul_a      = {7'b0, fz_reg};
                mul_b      = 34'(dv_reg[ax_reg]);
                state_next = msc_pkg::ST_LK_FB;
            end
            msc_pkg::ST_LK_FB:
            begin
                f_next     = msc_pkg::sat32(fq);
                state_next = msc_pkg::ST_LK_FC;
            end
            msc_pkg::ST_LK_FC:
            begin
                mul_a      = 34'(f_reg);
                mul_b      = 34'(dlt_reg[ax_reg]);
                state_next = msc_pkg::ST_LK_FD;
            end
            msc_pkg::ST_LK_FD:
            begin
                dv_start   = 1'b1;
                dv_num     = prod_reg;
                dv_den     = {1'b0, d_reg};
                state_next = msc_pkg::ST_LK_DIV;
            end
            // The projected force can reach +2^31, so it keeps 33 bits.
            msc_pkg::ST_LK_DIV:
            begin
                if (dv_done)
                begin
                    c_next     = dv_quot[32:0];
                    state_next = msc_pkg::ST_LK_WA;
                end
            end
            msc_pkg::ST_LK_WA:
            begin
                frc_we[ax_reg] = 1'b1;
                frc_wd[ax_reg] = msc_pkg::sat32(64'(rd_frc[ax_reg]) + 64'(c_reg));
                state_next     = msc_pkg::ST_LK_WB;
            end
            msc_pkg::ST_LK_WB:
            begin
                ad             = idx_reg + 1'b1;
                frc_we[ax_reg] = 1'b1;
                frc_wd[ax_reg] = msc_pkg::sat32(64'(rd_frc[ax_reg]) - 64'(c_reg));
                if (ax_reg != 2'd2)
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = msc_pkg::ST_LK_FA;
                end
                else if (link_done)
                begin
                    idx_next   = '0;
                    state_next = msc_pkg::ST_MS_GRAV;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = msc_pkg::ST_LK_RDA;
                end
            end

            // Mass: gravity, then velocity and position updates per axis for a free mass.
            msc_pkg::ST_MS_GRAV:
            begin
                frc_we[1] = 1'b1;
                frc_wd[1] = msc_pkg::sat32(64'(rd_frc[1]) - $signed({37'b0, grav_reg}));
                ax_next   = '0;
                state_next = rd_anch ? msc_pkg::ST_MS_CLR : msc_pkg::ST_MS_DV;
            end
            msc_pkg::ST_MS_DV:
            begin
                dv_start   = 1'b1;
                dv_num     = 64'(rd_frc[ax_reg]);
                dv_den     = {23'b0, fe};
                state_next = msc_pkg::ST_MS_DVW;
            end
            msc_pkg::ST_MS_DVW:
            begin
                if (dv_done)
                begin
                    vel_we[ax_reg] = 1'b1;
                    vel_wd[ax_reg] = msc_pkg::sat32(64'(rd_vel[ax_reg]) + dv_quot);
                    state_next     = msc_pkg::ST_MS_DP;
                end
            end
            msc_pkg::ST_MS_DP:
            begin
                dv_start   = 1'b1;
                dv_num     = 64'(rd_vel[ax_reg]);
                dv_den     = {23'b0, fe};
                state_next = msc_pkg::ST_MS_DPW;
            end
            msc_pkg::ST_MS_DPW:
            begin
                if (dv_done)
                begin
                    pos_we[ax_reg] = 1'b1;
                    pos_wd[ax_reg] = msc_pkg::sat32(64'(rd_pos[ax_reg]) + dv_quot);
                    if (ax_reg == 2'd2)
                    begin
                        state_next = msc_pkg::ST_MS_CLR;
                    end
                    else
                    begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = msc_pkg::ST_MS_DV;
                    end
                end
            end
            msc_pkg::ST_MS_CLR:
            begin
                frc_we     = 3'b111;
                frc_wd     = '{default: '0};
                state_next = msc_pkg::ST_MS_OUT;
            end

            // Report the mass once the output register is free.
            msc_pkg::ST_MS_OUT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next = 1'b1;
                    oload   = 1'b1;
                    if (8'(idx_reg) == 8'(n_last))
                    begin
                        state_next = msc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = msc_pkg::ST_MS_GRAV;
                    end
                end
            end

            default:
            begin
                state_next = msc_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msc_pkg::ST_IDLE;
            idx_reg   <= '0;
            ax_reg    <= '0;
            md_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ax_reg    <= ax_next;
            md_reg    <= md_next;
            ov_reg    <= ov_next;
        end
    end

    // Working datapath registers.
    always_ff @(posedge clk)
    begin
        pa_reg    <= pa_next;
        va_reg    <= va_next;
        dlt_reg   <= dlt_next;
        dv_reg    <= dv_next;
        acc_reg   <= acc_next;
        d_reg     <= d_next;
        fk_reg    <= fk_next;
        fz_reg    <= fz_next;
        grav_reg  <= grav_next;
        sterm_reg <= sterm_next;
        f_reg     <= f_next;
        c_reg     <= c_next;
        prod_reg  <= mul_full[63:0];
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (oload)
        begin
            oidx_reg  <= 4'(idx_reg);
            ox_reg    <= rd_pos[0];
            oy_reg    <= rd_pos[1];
            oz_reg    <= rd_pos[2];
            olast_reg <= (8'(idx_reg) == 8'(n_last));
        end
    end

    // Mass store writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < msc_pkg::NUM_MASSES; m++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    pos_reg[m][a]  <= '0;
                    vel_reg[m][a]  <= '0;
                    home_reg[m][a] <= '0;
                    frc_reg[m][a]  <= '0;
                end
                rest_reg[m] <= '0;
                anch_reg[m] <= 1'b1;
            end
        end
        else
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (pos_we[a])
                begin
                    pos_reg[ad][a] <= pos_wd[a];
                end
                if (vel_we[a])
                begin
                    vel_reg[ad][a] <= vel_wd[a];
                end
                if (frc_we[a])
                begin
                    frc_reg[ad][a] <= frc_wd[a];
                end
                if (home_we)
                begin
                    home_reg[ad][a] <= in_xyz[a];
                end
            end
            if (rest_we)
            begin
                rest_reg[ad] <= rest_wd;
            end
            if (anch_we)
            begin
                anch_reg[ad] <= anch_wd;
            end
        end
    end

    assign s_tready = (state_reg == msc_pkg::ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'b0, oz_reg, oy_reg, ox_reg, oidx_reg};
    assign m_tlast  = olast_reg;

endmodule

### rtl/msc_div.sv
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring divider, one quotient bit per cycle, quotient truncated to zero.
// ----------------------------------------------------------------------------
module msc_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic        [32:0] divisor,
    output logic               done,
    output logic signed [63:0] quot
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [msc_pkg::DIV_CW-1:0]    cnt_reg;
    logic                          neg_reg;
    logic [63:0]                   num_reg;
    logic [32:0]                   rem_reg;
    logic [32:0]                   den_reg;
    logic [33:0]                   raw;
    logic [33:0]                   diff;
    logic                          ge;
    logic [63:0]                   mag;

    // Trial subtraction for one quotient bit.
    assign raw  = {rem_reg, num_reg[63]};
    assign diff = raw - {1'b0, den_reg};
    assign ge   = (raw >= {1'b0, den_reg});
    assign mag  = dividend[63] ? 64'(-dividend) : 64'(dividend);

    // Control: busy flag, step counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == msc_pkg::DIV_CW'(msc_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out while quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= mag;
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[63];
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[62:0], ge};
            rem_reg <= ge ? diff[32:0] : raw[32:0];
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(num_reg) : $signed(num_reg);

endmodule

### rtl/msc_sqrt.sv
// ----------------------------------------------------------------------------
// Serial integer square root
// Digit-by-digit floor root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module msc_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] rad,
    output logic        done,
    output logic [31:0] root
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [msc_pkg::SQRT_CW-1:0]   cnt_reg;
    logic [63:0]                   rad_reg;
    logic [33:0]                   rem_reg;
    logic [31:0]                   root_reg;
    logic [35:0]                   raw;
    logic [35:0]                   trial;
    logic [35:0]                   diff;
    logic                          ge;

    // Bring down two radicand bits and try the next root bit.
    assign raw   = {rem_reg, rad_reg[63:62]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign diff  = raw - trial;
    assign ge    = (raw >= trial);

    // Control: busy flag, step counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == msc_pkg::SQRT_CW'(msc_pkg::SQRT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= ge ? diff[33:0] : raw[33:0];
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/msc_checker.sv
// ----------------------------------------------------------------------------
// Mass-spring chain port checker
// Watches the stream ports of the chain block over time.
// ----------------------------------------------------------------------------
`include "mass_spring_chain_step_assert.svh"

module msc_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [1:0]                  s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [msc_pkg::OUT_W-1:0]   m_tdata
);

    // A stalled result stays offered and unchanged.
    `MSCS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `MSCS_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

    // A tick or a restore occupies the sequencer; a load does not.
    `MSCS_ASSERT_NXT(a_busy_after_run, s_tvalid && s_tready && (s_tuser == msc_pkg::OP_TICK || s_tuser == msc_pkg::OP_RESTORE), !s_tready, "ready after a tick or restore transfer")
    `MSCS_ASSERT_NXT(a_ready_after_load, s_tvalid && s_tready && s_tuser == msc_pkg::OP_LOAD, s_tready, "not ready after a load transfer")

    // Padding bits of a result are zero.
    `MSCS_ASSERT_NOW(a_out_pad, m_tvalid, m_tdata[msc_pkg::OUT_W-1:100] == '0, "nonzero padding in result")

endmodule

bind mass_spring_chain_step msc_checker u_msc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
